/* design/cld_pkg.sv */
// Shared types, constants and helpers for the content-length message deframer.
// No dependencies; imported by cld_step, the top level and cld_checker.
package cld_pkg;

	localparam int LENGTH_BITS = 32;
	// Working width for the length multiply-add: room for acc*10+9 and the 32-bit limit
	localparam int ACC_W = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 4;

	localparam logic [4:0] PREFIX_LEN = 5'd16;
	localparam logic [127:0] HDR_PREFIX = "Content-Length: ";

	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [7:0] CHR_0 = 8'h30;
	localparam logic [7:0] CHR_9 = 8'h39;

	localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

	localparam logic [1:0] KIND_BODY = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_CR_NO_LF = 3'd1;
	localparam logic [2:0] ERR_HEADER = 3'd2;
	localparam logic [2:0] ERR_LENGTH = 3'd3;
	localparam logic [2:0] ERR_SEPARATOR = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_HDR_CR,
		PH_SEP_CR,
		PH_SEP_LF,
		PH_BODY
	} phase_t;

	typedef struct packed {
		phase_t                   phase;
		logic [4:0]               line_pos;
		logic                     prefix_mismatch;
		logic                     length_bad;
		logic                     digit_seen;
		logic [LENGTH_BITS-1:0]   acc;
		logic [LENGTH_BITS-1:0]   remaining;
	} parse_state_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] body_byte;
		logic       last;
		logic [2:0] err;
	} result_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		return HDR_PREFIX[8*(15 - int'(idx)) +: 8];
	endfunction

	// Fresh header line; the body count is left alone
	function automatic parse_state_t start_line(input parse_state_t s);
		parse_state_t r;
		r = s;
		r.phase = PH_HEADER;
		r.line_pos = '0;
		r.prefix_mismatch = 1'b0;
		r.length_bad = 1'b0;
		r.digit_seen = 1'b0;
		r.acc = '0;
		return r;
	endfunction

	function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] b,
		input logic last, input logic [2:0] err);
		result_t r;
		r.valid = 1'b1;
		r.kind = kind;
		r.body_byte = b;
		r.last = last;
		r.err = err;
		return r;
	endfunction

endpackage

/* design/cld_step.sv */
// Per-byte parser step: next parse state and optional result for one stream byte.
// Depends on cld_pkg.
module cld_step
	import cld_pkg::*;
(
	input  parse_state_t cur,
	input  logic [7:0]   stream_byte,
	input  logic [31:0]  max_body_length,
	output parse_state_t nxt,
	output result_t      res
);

	localparam logic [ACC_W-1:0] WORD_MAX = {{(ACC_W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

	logic [ACC_W-1:0] max_w;
	logic [ACC_W-1:0] limit;
	logic [ACC_W-1:0] acc_w;
	logic [ACC_W-1:0] acc_next;
	logic             is_digit;
	logic [3:0]       digit;
	logic             prefix_ok_byte;

	assign max_w = {{(ACC_W-32){1'b0}}, max_body_length};
	assign limit = (max_w < WORD_MAX) ? max_w : WORD_MAX;
	assign acc_w = {{(ACC_W-LENGTH_BITS){1'b0}}, cur.acc};
	assign is_digit = (stream_byte >= CHR_0) && (stream_byte <= CHR_9);
	assign digit = 4'(stream_byte - CHR_0);
	assign acc_next = (acc_w << 3) + (acc_w << 1) + {{(ACC_W-4){1'b0}}, digit};
	assign prefix_ok_byte = (stream_byte == prefix_char(cur.line_pos[3:0]));

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_HEADER: begin
				if (stream_byte == CHR_CR) begin
					nxt.phase = PH_HDR_CR;
				end else if (stream_byte == CHR_LF) begin
					// end of line: judge it
					if (cur.line_pos == 5'd0) begin
						nxt = start_line(cur);
						res = make_result(KIND_EMPTY, 8'd0, 1'b0, ERR_NONE);
					end else if (cur.prefix_mismatch || cur.line_pos < PREFIX_LEN) begin
						nxt = start_line(cur);
						res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_HEADER);
					end else if (cur.length_bad || !cur.digit_seen) begin
						nxt = start_line(cur);
						res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_LENGTH);
					end else begin
						nxt.remaining = cur.acc;
						nxt.phase = PH_SEP_CR;
					end
				end else if (cur.line_pos < PREFIX_LEN) begin
					if (!prefix_ok_byte) begin
						nxt.prefix_mismatch = 1'b1;
					end
					nxt.line_pos = cur.line_pos + 5'd1;
				end else if (!cur.length_bad) begin
					if (is_digit) begin
						if (acc_next > limit) begin
							nxt.length_bad = 1'b1;
						end else begin
							nxt.acc = acc_next[LENGTH_BITS-1:0];
						end
						nxt.digit_seen = 1'b1;
					end else begin
						nxt.length_bad = 1'b1;
					end
				end
			end
			PH_HDR_CR: begin
				if (stream_byte == CHR_LF) begin
					if (cur.line_pos == 5'd0) begin
						nxt = start_line(cur);
						res = make_result(KIND_EMPTY, 8'd0, 1'b0, ERR_NONE);
					end else if (cur.prefix_mismatch || cur.line_pos < PREFIX_LEN) begin
						nxt = start_line(cur);
						res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_HEADER);
					end else if (cur.length_bad || !cur.digit_seen) begin
						nxt = start_line(cur);
						res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_LENGTH);
					end else begin
						nxt.remaining = cur.acc;
						nxt.phase = PH_SEP_CR;
					end
				end else begin
					nxt = start_line(cur);
					res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_CR_NO_LF);
				end
			end
			PH_SEP_CR: begin
				if (stream_byte == CHR_CR) begin
					nxt.phase = PH_SEP_LF;
				end else begin
					nxt = start_line(cur);
					res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_SEPARATOR);
				end
			end
			PH_SEP_LF: begin
				if (stream_byte != CHR_LF) begin
					nxt = start_line(cur);
					res = make_result(KIND_ERROR, 8'd0, 1'b0, ERR_SEPARATOR);
				end else if (cur.remaining == '0) begin
					nxt = start_line(cur);
					res = make_result(KIND_EMPTY, 8'd0, 1'b0, ERR_NONE);
				end else begin
					nxt.phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (cur.remaining <= LENGTH_BITS'(1)) begin
					nxt = start_line(cur);
					nxt.remaining = '0;
					res = make_result(KIND_BODY, stream_byte, 1'b1, ERR_NONE);
				end else begin
					nxt.remaining = cur.remaining - LENGTH_BITS'(1);
					res = make_result(KIND_BODY, stream_byte, 1'b0, ERR_NONE);
				end
			end
			default: begin
				nxt = start_line(cur);
			end
		endcase
	end

endmodule

/* design/content_length_message_deframer_unit.sv */
// Content-length message deframer top level: input register, parser state, result register.
// Depends on cld_pkg and cld_step.
//
//   channel   signals                                      direction
//   input     in_valid, in_stall, stream_byte              byte stream in
//   output    out_valid, out_stall, kind, body_byte,       result out
//             last_of_body, error_code
//   config    cfg_valid, cfg_ready, cfg_data               max_body_length write
//
// One byte per cycle sustained while the output is not stalled; a byte enters the input register
// when it is accepted, and its result, if any, is then registered in the result register.
// The byte-to-byte path is the length multiply-by-ten, add and limit compare.
// Reset clears the parse state and the valid flags; max_body_length resets to 1048576.
// A stalled output holds a full input register, which then stalls the input side.
// cfg_ready is always high.
module content_length_message_deframer_unit
	import cld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  body_byte,
	output logic        last_of_body,
	output logic [2:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	logic [1:0]   kind_q;
	logic [7:0]   body_byte_q;
	logic         last_q;
	logic [2:0]   err_q;
	logic [31:0]  max_len_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      step_res;
	logic         advance;

	cld_step u_step (
		.cur             (state_q),
		.stream_byte     (byte_s1),
		.max_body_length (max_len_q),
		.nxt             (state_nxt),
		.res             (step_res)
	);

	// Result slot is free or being taken this cycle
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= start_line('0);
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && step_res.valid) begin
			kind_q <= step_res.kind;
			body_byte_q <= step_res.body_byte;
			last_q <= step_res.last;
			err_q <= step_res.err;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign body_byte = body_byte_q;
	assign last_of_body = last_q;
	assign error_code = err_q;

endmodule

/* design/cld_checker.sv */
// Port-level checks for the content-length message deframer, bound to the top level.
// Depends on cld_pkg and content_length_message_deframer_unit.
module cld_checker
	import cld_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [7:0]  body_byte,
	input logic        last_of_body,
	input logic [2:0]  error_code
);

	// Body bytes carry no error code
	a_body_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BODY |-> error_code == ERR_NONE)
		else $error("body result with error code");

	// Empty message carries nothing else
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |->
			body_byte == 8'd0 && !last_of_body && error_code == ERR_NONE)
		else $error("empty message with payload");

	// Errors carry a real code, no data
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> !last_of_body && body_byte == 8'd0 &&
			(error_code == ERR_CR_NO_LF || error_code == ERR_HEADER ||
			 error_code == ERR_LENGTH || error_code == ERR_SEPARATOR))
		else $error("bad error result");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_BODY || kind == KIND_EMPTY || kind == KIND_ERROR)
		else $error("undefined result kind");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(body_byte) &&
			$stable(last_of_body) && $stable(error_code))
		else $error("stalled result changed");

endmodule

bind content_length_message_deframer_unit cld_checker u_cld_checker (.*);
